// ----- design/rtc_bcd_time_codec_unit_macros.svh -----
// assertion macros for the rtc bcd time codec checker
// depends on a clk and rst signal in the scope of each use
`ifndef RTC_BCD_TIME_CODEC_UNIT_MACROS_SVH
`define RTC_BCD_TIME_CODEC_UNIT_MACROS_SVH

// property checked only outside reset
`define RTCBCD_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("rtcbcd assertion failed");

// property checked at every edge, reset included
`define RTCBCD_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) (expr)) \
    else $error("rtcbcd assertion failed during or after reset");

`endif

// ----- design/rtcbcd_pkg.sv -----
// types, constants and conversion helpers for the rtc bcd time codec
// no dependencies
`timescale 1ns / 1ps

package rtcbcd_pkg;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } rtcbcd_op_t;

  localparam logic [11:0] YEAR_MIN    = 12'd2000;
  localparam logic [11:0] YEAR_MAX    = 12'd2099;
  localparam logic [3:0]  MONTH_MIN   = 4'd1;
  localparam logic [3:0]  MONTH_MAX   = 4'd12;
  localparam logic [3:0]  MONTH_MARCH = 4'd3;
  localparam logic [4:0]  DAY_MIN     = 5'd1;
  localparam logic [4:0]  HOUR_MAX    = 5'd23;
  localparam logic [5:0]  MINSEC_MAX  = 6'd59;

  // weekday sum is taken relative to a leap-cycle aligned year;
  // the dropped part of the sum leaves this remainder mod 7
  localparam logic [11:0] WDAY_BASE_YEAR = 12'd1996;
  localparam logic [7:0]  WDAY_BIAS      = 8'd2;

  localparam logic [7:0] MASK_MINSEC = 8'h7F;
  localparam logic [7:0] MASK_HRDAY  = 8'h3F;
  localparam logic [7:0] MASK_MONTH  = 8'h1F;
  localparam logic [7:0] MASK_WDAY   = 8'h07;

  typedef struct packed {
    rtcbcd_op_t   operation;
    logic [11:0]  year;
    logic [3:0]   month;
    logic [4:0]   day;
    logic [4:0]   hour;
    logic [5:0]   minute;
    logic [5:0]   second;
    logic [55:0]  reg_image;
  } rtcbcd_req_t;

  typedef struct packed {
    logic         status;
    logic [55:0]  image_out;
    logic [11:0]  year_out;
    logic [4:0]   month_out;
    logic [5:0]   day_out;
    logic [5:0]   hour_out;
    logic [6:0]   minute_out;
    logic [6:0]   second_out;
    logic [2:0]   weekday_out;
  } rtcbcd_rsp_t;

  // two bcd digits of a value below 100; tens by reciprocal multiply
  function automatic logic [7:0] rtcbcd_bin2bcd(input logic [6:0] v);
    logic [13:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = 14'(v) * 14'd103;
    tens = prod[13:10];
    ones = v - (7'({tens, 3'b000}) + 7'({tens, 1'b0}));
    return {tens, ones[3:0]};
  endfunction

  // high digit times ten plus low digit, digits unchecked
  function automatic logic [7:0] rtcbcd_bcd2bin(input logic [7:0] b);
    return {b[7:4], 3'b000} + {2'b00, b[7:4], 1'b0} + {4'b0000, b[3:0]};
  endfunction

  // 8 is 1 mod 7, so fold octal digits then fix up
  function automatic logic [2:0] rtcbcd_mod7(input logic [7:0] s);
    logic [4:0] a;
    logic [3:0] b;
    logic [3:0] c;
    a = 5'(s[7:6]) + 5'(s[5:3]) + 5'(s[2:0]);
    b = 4'(a[4:3]) + 4'(a[2:0]);
    c = 4'(b[3]) + 4'(b[2:0]);
    return (c >= 4'd7) ? 3'(c - 4'd7) : c[2:0];
  endfunction

  // sakamoto month offsets, january first
  function automatic logic [2:0] rtcbcd_month_offset(input logic [3:0] m);
    logic [2:0] off;
    case (m)
      4'd1:    off = 3'd0;
      4'd2:    off = 3'd3;
      4'd3:    off = 3'd2;
      4'd4:    off = 3'd5;
      4'd5:    off = 3'd0;
      4'd6:    off = 3'd3;
      4'd7:    off = 3'd5;
      4'd8:    off = 3'd1;
      4'd9:    off = 3'd4;
      4'd10:   off = 3'd6;
      4'd11:   off = 3'd2;
      4'd12:   off = 3'd4;
      default: off = 3'd0;
    endcase
    return off;
  endfunction

endpackage

// ----- design/rtcbcd_stream_if.sv -----
// valid/ready channel carrying one payload struct per request
// payload type is given by the instantiating scope
`timescale 1ns / 1ps

interface rtcbcd_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/rtc_bcd_time_codec_unit.sv -----
// rtc bcd time codec top level: input register, conversion logic, result register
// depends on rtcbcd_pkg and rtcbcd_stream_if
`timescale 1ns / 1ps

// Usage
//   req carries one conversion request: operation selects encode (calendar
//   fields to a seven-byte bcd register image with weekday) or decode
//   (register image to binary fields). rsp carries one result per request.
//   Both channels move a request when valid and ready are high at a clock edge.
// Pipeline and throughput
//   two registers deep: a request is captured in the input register at the
//   accepting edge, converted by combinational logic and loaded into the
//   result register when that register is empty or being drained, which
//   raises rsp.valid. One request per cycle is taken when rsp is not stalled.
// Stall behavior
//   a result held on rsp stays stable until taken; the input register still
//   takes one more request meanwhile, then req.ready drops until rsp moves.
// Reset
//   rst (synchronous, active high) empties both registers; no result is
//   presented and req.ready is high in the first cycle after reset.
// Encode errors
//   out-of-range fields give status 1 with a zero image; decoded fields are
//   zero on encode, and status and image are zero on decode.
module rtc_bcd_time_codec_unit (
  input logic           clk,
  input logic           rst,
  rtcbcd_stream_if.sink   req,
  rtcbcd_stream_if.source rsp
);
  import rtcbcd_pkg::*;

  // pipeline registers
  logic        s1_valid;
  rtcbcd_req_t s1_req;
  logic        s2_valid;
  rtcbcd_rsp_t out_data;

  // handshake
  logic rsp_load;

  // conversion results
  rtcbcd_rsp_t result;
  logic        enc_ok;
  logic [11:0] year_rel;
  logic [6:0]  wday_year;
  logic [7:0]  wday_sum;
  logic [2:0]  wday;
  logic [7:0]  yr_bin;

  // result register loads when it is empty or being drained
  assign rsp_load  = s1_valid && (!s2_valid || rsp.ready);
  assign req.ready = !s1_valid || rsp_load;

  assign rsp.valid   = s2_valid;
  assign rsp.payload = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (req.ready) begin
        s1_valid <= req.valid;
      end
      if (rsp_load) begin
        s2_valid <= 1'b1;
      end else if (rsp.ready) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_req <= req.payload;
    end
    if (rsp_load) begin
      out_data <= result;
    end
  end

  always_comb begin
    result = '0;

    // encode range check; month lengths are not checked
    enc_ok = (s1_req.year >= YEAR_MIN) && (s1_req.year <= YEAR_MAX) &&
             (s1_req.month >= MONTH_MIN) && (s1_req.month <= MONTH_MAX) &&
             (s1_req.day >= DAY_MIN) && (s1_req.hour <= HOUR_MAX) &&
             (s1_req.minute <= MINSEC_MAX) && (s1_req.second <= MINSEC_MAX);

    // weekday: january and february count in the previous year
    year_rel  = s1_req.year - WDAY_BASE_YEAR -
                ((s1_req.month < MONTH_MARCH) ? 12'd1 : 12'd0);
    wday_year = year_rel[6:0];
    wday_sum  = WDAY_BIAS + 8'(wday_year) + 8'(wday_year[6:2]) +
                8'(rtcbcd_month_offset(s1_req.month)) + 8'(s1_req.day);
    wday      = rtcbcd_mod7(wday_sum);

    yr_bin = rtcbcd_bcd2bin(s1_req.reg_image[55:48]);

    if (s1_req.operation == OP_ENCODE) begin
      if (enc_ok) begin
        result.image_out = {rtcbcd_bin2bcd(7'(s1_req.year - YEAR_MIN)),
                            rtcbcd_bin2bcd(7'(s1_req.month)),
                            rtcbcd_bin2bcd(7'(s1_req.day)),
                            5'b00000, wday,
                            rtcbcd_bin2bcd(7'(s1_req.hour)),
                            rtcbcd_bin2bcd(7'(s1_req.minute)),
                            rtcbcd_bin2bcd(7'(s1_req.second))};
      end else begin
        result.status = 1'b1;
      end
    end else begin
      result.year_out    = YEAR_MIN + 12'(yr_bin);
      result.month_out   = 5'(rtcbcd_bcd2bin(s1_req.reg_image[47:40] & MASK_MONTH));
      result.day_out     = 6'(rtcbcd_bcd2bin(s1_req.reg_image[39:32] & MASK_HRDAY));
      result.hour_out    = 6'(rtcbcd_bcd2bin(s1_req.reg_image[23:16] & MASK_HRDAY));
      result.minute_out  = 7'(rtcbcd_bcd2bin(s1_req.reg_image[15:8] & MASK_MINSEC));
      result.second_out  = 7'(rtcbcd_bcd2bin(s1_req.reg_image[7:0] & MASK_MINSEC));
      result.weekday_out = 3'(s1_req.reg_image[31:24] & MASK_WDAY);
    end
  end

endmodule

// ----- design/rtcbcd_checker.sv -----
// port-level checks for the rtc bcd time codec, bound to the top level
// depends on rtcbcd_pkg and rtc_bcd_time_codec_unit_macros.svh
`timescale 1ns / 1ps
`include "rtc_bcd_time_codec_unit_macros.svh"

module rtcbcd_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    req_valid,
  input logic                    req_ready,
  input logic                    rsp_valid,
  input logic                    rsp_ready,
  input rtcbcd_pkg::rtcbcd_rsp_t rsp_payload
);
  import rtcbcd_pkg::*;

  // reset empties the result register
  `RTCBCD_ASSERT_ALWAYS(a_reset_empty, rst |=> !rsp_valid)

  // a stalled result holds
  `RTCBCD_ASSERT(a_stall_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))

  // an encode error never carries an image
  `RTCBCD_ASSERT(a_err_zero, rsp_valid && rsp_payload.status |-> rsp_payload.image_out == '0)

  // input side never blocks while nothing is pending downstream
  `RTCBCD_ASSERT(a_ready_free, !rsp_valid && !$past(req_valid && req_ready) |-> req_ready)

endmodule

bind rtc_bcd_time_codec_unit rtcbcd_checker u_rtcbcd_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_payload (rsp.payload)
);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

// testbench for rtc_bcd_time_codec_unit: directed and random encode/decode requests,
// each result checked field by field against an in-bench calendar/bcd predictor
// depends on rtcbcd_pkg, rtcbcd_stream_if and rtc_bcd_time_codec_unit
module tb_top;
  import rtcbcd_pkg::*;

  localparam int unsigned MAX_IDLE    = 18;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned TAIL_CYCLES = 12;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned HOLD_LEN    = 250;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  logic clk;
  logic rst;

  rtcbcd_stream_if #(.payload_t(rtcbcd_req_t)) req_if ();
  rtcbcd_stream_if #(.payload_t(rtcbcd_rsp_t)) rsp_if ();

  rtc_bcd_time_codec_unit u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  // results predicted at request acceptance, oldest first
  rtcbcd_rsp_t expected_rsp_q [$];

  int unsigned n_cycles;
  int unsigned n_taken;
  int unsigned n_checked;
  int unsigned n_mismatch;
  int unsigned n_encode;
  int unsigned n_reject;
  int unsigned n_decode;

  // sender idling is only touched by the stimulus process
  bit          tx_idle_on;
  // receiver idling and hold-off are set with nonblocking assignments in the test tasks
  bit          rx_idle_on;
  int unsigned hold_req;
  bit          rsp_hold;
  int unsigned rx_left;
  int unsigned rx_seen;

  // 12 ns clock, high and low halves
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // watchdog on total run length
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               n_cycles, expected_rsp_q.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // two decimal digits of a value below 100
  function automatic logic [7:0] to_bcd2(input int unsigned v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  // high digit times ten plus low digit, no digit check
  function automatic int unsigned from_bcd2(input logic [7:0] b);
    return 32'(b[7:4]) * 10 + 32'(b[3:0]);
  endfunction

  // per-month offset of the weekday sum, january first
  function automatic int unsigned month_shift(input int unsigned m);
    int unsigned s;
    case (m)
      1:       s = 0;
      2:       s = 3;
      3:       s = 2;
      4:       s = 5;
      5:       s = 0;
      6:       s = 3;
      7:       s = 5;
      8:       s = 1;
      9:       s = 4;
      10:      s = 6;
      11:      s = 2;
      12:      s = 4;
      default: s = 0;
    endcase
    return s;
  endfunction

  // weekday with 0 for sunday; january and february count in the year before
  function automatic logic [2:0] calc_weekday(input int unsigned y, input int unsigned m,
                                              input int unsigned d);
    int unsigned yy;
    yy = (m < 3) ? y - 1 : y;
    return 3'((yy + yy / 4 - yy / 100 + yy / 400 + month_shift(m) + d) % 7);
  endfunction

  function automatic rtcbcd_rsp_t predict_codec(input rtcbcd_req_t rq);
    rtcbcd_rsp_t res;
    int unsigned yr;
    int unsigned mo;
    int unsigned dy;
    int unsigned hr;
    int unsigned mi;
    int unsigned sc;
    res = '0;
    if (rq.operation == OP_ENCODE) begin
      yr = rq.year;
      mo = rq.month;
      dy = rq.day;
      hr = rq.hour;
      mi = rq.minute;
      sc = rq.second;
      // any field out of range: invalid status, image stays zero
      if (yr < YEAR_MIN || yr > YEAR_MAX || mo < MONTH_MIN || mo > MONTH_MAX ||
          dy < DAY_MIN || hr > HOUR_MAX || mi > MINSEC_MAX || sc > MINSEC_MAX) begin
        res.status = STATUS_INVALID;
      end else begin
        res.status    = STATUS_OK;
        res.image_out = {to_bcd2(yr - YEAR_MIN), to_bcd2(mo), to_bcd2(dy),
                         5'd0, calc_weekday(yr, mo, dy),
                         to_bcd2(hr), to_bcd2(mi), to_bcd2(sc)};
      end
    end else begin
      // decode: mask every byte but the year, weekday keeps its low three bits, the rest go unchecked bcd to binary
      res.year_out    = 12'(32'(YEAR_MIN) + from_bcd2(rq.reg_image[55:48]));
      res.month_out   = 5'(from_bcd2(rq.reg_image[47:40] & MASK_MONTH));
      res.day_out     = 6'(from_bcd2(rq.reg_image[39:32] & MASK_HRDAY));
      res.weekday_out = rq.reg_image[26:24];
      res.hour_out    = 6'(from_bcd2(rq.reg_image[23:16] & MASK_HRDAY));
      res.minute_out  = 7'(from_bcd2(rq.reg_image[15:8] & MASK_MINSEC));
      res.second_out  = 7'(from_bcd2(rq.reg_image[7:0] & MASK_MINSEC));
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // request builders
  // ---------------------------------------------------------------------------

  function automatic logic [55:0] rand_image();
    return {24'($urandom), $urandom};
  endfunction

  // every field drawn over its whole width
  function automatic rtcbcd_req_t rand_any(input rtcbcd_op_t op);
    rtcbcd_req_t rq;
    rq.operation = op;
    rq.year      = 12'($urandom);
    rq.month     = 4'($urandom);
    rq.day       = 5'($urandom);
    rq.hour      = 5'($urandom);
    rq.minute    = 6'($urandom);
    rq.second    = 6'($urandom);
    rq.reg_image = rand_image();
    return rq;
  endfunction

  function automatic rtcbcd_req_t make_encode(input int unsigned y, input int unsigned mo,
                                              input int unsigned d, input int unsigned h,
                                              input int unsigned mi, input int unsigned s);
    rtcbcd_req_t rq;
    rq = rand_any(OP_ENCODE);
    rq.year   = 12'(y);
    rq.month  = 4'(mo);
    rq.day    = 5'(d);
    rq.hour   = 5'(h);
    rq.minute = 6'(mi);
    rq.second = 6'(s);
    return rq;
  endfunction

  function automatic rtcbcd_req_t rand_valid_encode();
    return make_encode($urandom_range(YEAR_MIN, YEAR_MAX), $urandom_range(1, 12),
                       $urandom_range(1, 31), $urandom_range(0, 23),
                       $urandom_range(0, 59), $urandom_range(0, 59));
  endfunction

  // valid request with exactly one field pushed out of range
  function automatic rtcbcd_req_t rand_bad_encode();
    rtcbcd_req_t rq;
    int unsigned m;
    rq = rand_valid_encode();
    case ($urandom_range(0, 5))
      0: rq.year = ($urandom_range(0, 1) != 0) ? 12'($urandom_range(0, 1999))
                                               : 12'($urandom_range(2100, 4095));
      1: begin
        m = $urandom_range(0, 3);
        rq.month = (m == 0) ? 4'd0 : 4'(12 + m);
      end
      2: rq.day    = 5'd0;
      3: rq.hour   = 5'($urandom_range(24, 31));
      4: rq.minute = 6'($urandom_range(60, 63));
      default: rq.second = 6'($urandom_range(60, 63));
    endcase
    return rq;
  endfunction

  // decode of a random image, sometimes of a well-formed one
  function automatic rtcbcd_req_t rand_decode();
    rtcbcd_req_t rq;
    rtcbcd_rsp_t enc;
    rq = rand_any(OP_DECODE);
    if ($urandom_range(0, 4) == 0) begin
      enc = predict_codec(rand_valid_encode());
      rq.reg_image = enc.image_out;
    end
    return rq;
  endfunction

  function automatic rtcbcd_req_t make_decode(input logic [55:0] img);
    rtcbcd_req_t rq;
    rq = rand_any(OP_DECODE);
    rq.reg_image = img;
    return rq;
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: one request, idle gap first, then hold until accepted
  // ---------------------------------------------------------------------------
  task automatic send_req(input rtcbcd_req_t rq);
    int unsigned gap;
    rtcbcd_rsp_t want;
    gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= rq;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
    // accepted at this edge
    want = predict_codec(rq);
    expected_rsp_q.push_back(want);
    if (rq.operation == OP_DECODE) begin
      n_decode++;
    end else begin
      n_encode++;
      if (want.status == STATUS_INVALID) n_reject++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  function automatic void cmp_field(input string fname, input logic [63:0] want,
                                    input logic [63:0] got);
    if (want !== got) begin
      n_mismatch++;
      if (n_mismatch <= MAX_REPORTS)
        $display("result %0d: %s expected %h got %h", n_checked, fname, want, got);
    end
  endfunction

  // compare each taken result with the oldest prediction
  always @(posedge clk) begin : rsp_checker
    rtcbcd_rsp_t want;
    rtcbcd_rsp_t got;
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      got = rsp_if.payload;
      n_taken++;
      if (expected_rsp_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS)
          $display("unexpected result: status %b image %h", got.status, got.image_out);
      end else begin
        want = expected_rsp_q.pop_front();
        cmp_field("status", 64'(want.status), 64'(got.status));
        cmp_field("image_out", 64'(want.image_out), 64'(got.image_out));
        cmp_field("year_out", 64'(want.year_out), 64'(got.year_out));
        cmp_field("month_out", 64'(want.month_out), 64'(got.month_out));
        cmp_field("day_out", 64'(want.day_out), 64'(got.day_out));
        cmp_field("hour_out", 64'(want.hour_out), 64'(got.hour_out));
        cmp_field("minute_out", 64'(want.minute_out), 64'(got.minute_out));
        cmp_field("second_out", 64'(want.second_out), 64'(got.second_out));
        cmp_field("weekday_out", 64'(want.weekday_out), 64'(got.weekday_out));
        n_checked++;
      end
    end
  end

  // long receiver hold-off, counted in cycles here
  initial begin : rsp_hold_counter
    rsp_hold = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        rsp_hold = 1'b1;
        repeat (hold_req) @(posedge clk);
        rsp_hold = 1'b0;
        hold_req = 0;
      end
    end
  end

  // receiver ready: fresh idle draw after each taken result
  always @(negedge clk) begin
    if (n_taken != rx_seen) begin
      rx_seen = n_taken;
      rx_left = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    end
    if (rx_left > 0) begin
      rx_left = rx_left - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= !rsp_hold;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // range edges of every encode field, weekday around the march boundary
  task automatic test_encode_corners();
    send_req(make_encode(2000, 1, 1, 0, 0, 0));      // all minimums, january
    send_req(make_encode(2099, 12, 31, 23, 59, 59)); // all maximums
    send_req(make_encode(2000, 2, 29, 12, 30, 30));  // leap day, year before counts
    send_req(make_encode(2024, 3, 1, 6, 7, 8));      // first month without shift
    send_req(make_encode(2099, 2, 31, 1, 2, 3));     // month length not checked
    send_req(make_encode(1999, 6, 15, 10, 10, 10));  // year just below
    send_req(make_encode(2100, 6, 15, 10, 10, 10));  // year just above
    send_req(make_encode(0, 6, 15, 10, 10, 10));
    send_req(make_encode(4095, 6, 15, 10, 10, 10));
    send_req(make_encode(2050, 0, 15, 10, 10, 10));  // month zero
    send_req(make_encode(2050, 13, 15, 10, 10, 10));
    send_req(make_encode(2050, 15, 15, 10, 10, 10));
    send_req(make_encode(2050, 7, 0, 10, 10, 10));   // day zero
    send_req(make_encode(2050, 7, 20, 24, 10, 10));  // hour just above
    send_req(make_encode(2050, 7, 20, 31, 10, 10));
    send_req(make_encode(2050, 7, 20, 10, 60, 10));  // minute just above
    send_req(make_encode(2050, 7, 20, 10, 63, 10));
    send_req(make_encode(2050, 7, 20, 10, 10, 60));  // second just above
    send_req(make_encode(2050, 7, 20, 10, 10, 63));
  endtask

  // decode of empty, full, non-decimal and well-formed images
  task automatic test_decode_corners();
    send_req(make_decode(56'h0));
    send_req(make_decode(56'hFF_FF_FF_FF_FF_FF_FF));
    send_req(make_decode(56'hAA_AA_AA_AA_AA_AA_AA));   // digits above nine
    send_req(make_decode(56'h99_12_31_06_23_59_59));
    send_req(make_decode(56'hFF_E0_C0_F8_C0_80_80));   // only the masked-off bits set, year byte full
  endtask

  // mixed random requests, idle modes reshuffled every few dozen
  task automatic test_random_mix(input int unsigned n);
    int unsigned pick;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on <= ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 40)
        send_req(rand_valid_encode());
      else if (pick < 55)
        send_req(rand_bad_encode());
      else if (pick < 65)
        send_req(rand_any(OP_ENCODE));
      else
        send_req(rand_decode());
    end
  endtask

  // receiver stalls for a long stretch while requests keep coming
  task automatic test_stall_fill(input int unsigned n);
    tx_idle_on = 1'b0;
    rx_idle_on <= 1'b0;
    hold_req   <= HOLD_LEN;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 1) != 0)
        send_req(rand_valid_encode());
      else
        send_req(rand_decode());
    end
    tx_idle_on = 1'b1;
    rx_idle_on <= 1'b1;
  endtask

  // full rate on both sides
  task automatic test_back_to_back(input int unsigned n);
    tx_idle_on = 1'b0;
    rx_idle_on <= 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0)
        send_req(rand_decode());
      else if ($urandom_range(0, 3) == 0)
        send_req(rand_bad_encode());
      else
        send_req(rand_valid_encode());
    end
    tx_idle_on = 1'b1;
    rx_idle_on <= 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst            = 1'b1;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    rsp_if.ready   = 1'b0;
    tx_idle_on     = 1'b1;
    rx_idle_on     = 1'b1;
    hold_req       = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_encode_corners();
    test_decode_corners();
    test_random_mix(250);
    test_stall_fill(40);
    test_back_to_back(60);
    test_random_mix(150);

    @(negedge clk);
    req_if.valid <= 1'b0;

    // drain, then wait out the tail to catch stray results
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d encode requests (%0d out of range) and %0d decode requests",
             n_encode, n_reject, n_decode);
    $display("checked %0d results with %0d mismatches, one %0d-cycle receiver stall",
             n_checked, n_mismatch, HOLD_LEN);
    if (n_mismatch == 0 && expected_rsp_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ----- rtc_bcd_time_codec_unit.f -----
+incdir+design
design/rtcbcd_pkg.sv
design/rtcbcd_stream_if.sv
design/rtc_bcd_time_codec_unit.sv
design/rtcbcd_checker.sv
tb/sv/tb_top.sv
